[hdl/tnps_pkg.sv]
// ----------------------------------------------------------------------------
// tnps_pkg: shared types and constants of the thermal plant step unit
// Holds the serial unit request and result types, fixed-point constants and
// the exponential lookup tables used for the flow effectiveness.
// ----------------------------------------------------------------------------
package tnps_pkg;

  localparam int DW   = 56;
  localparam int MW   = 20;
  localparam int DENW = 32;

  localparam logic [2:0] REG_POWER = 3'd0;
  localparam logic [2:0] REG_MASS  = 3'd1;
  localparam logic [2:0] REG_LOSS  = 3'd2;
  localparam logic [2:0] REG_AMB   = 3'd3;
  localparam logic [2:0] REG_FLOWK = 3'd4;
  localparam logic [2:0] REG_DWH   = 3'd5;
  localparam logic [2:0] REG_DWS   = 3'd6;
  localparam logic [2:0] REG_DSH   = 3'd7;

  localparam logic [18:0] CP_Q16       = 19'd274334;
  localparam logic [16:0] COND_NUM     = 17'd81920;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] PENDING_MAX  = 17'd131071;
  localparam logic [11:0] FLOW_EPS_RAW = 12'd2;
  localparam logic signed [17:0] TEMP_CEIL    = 18'sd76800;
  localparam logic signed [17:0] FLOOR_OFFSET = 18'sd2560;

  localparam logic [17:0] D_HEATER = 18'd25600;
  localparam logic [17:0] D_BLOCK3 = 18'd230400;
  localparam logic [17:0] D_BLOCK1 = 18'd256000;
  localparam logic [17:0] D_SENSOR = 18'd12800;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] mcand;
    logic [MW-1:0]        mplier;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] num;
    logic [DENW-1:0]      den;
    logic                 rnd;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] value;
  } unit_res_t;

  // exp(-n) in q16, zero from n = 12 on
  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] v;
    begin
      case (n)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd24109;
        4'd2:    v = 17'd8869;
        4'd3:    v = 17'd3263;
        4'd4:    v = 17'd1200;
        4'd5:    v = 17'd442;
        4'd6:    v = 17'd162;
        4'd7:    v = 17'd60;
        4'd8:    v = 17'd22;
        4'd9:    v = 17'd8;
        4'd10:   v = 17'd3;
        4'd11:   v = 17'd1;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  // exp(-i/16) in q16
  function automatic logic [16:0] exp_frac(input logic [3:0] i);
    logic [16:0] v;
    begin
      case (i)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd61565;
        4'd2:    v = 17'd57835;
        4'd3:    v = 17'd54331;
        4'd4:    v = 17'd51039;
        4'd5:    v = 17'd47947;
        4'd6:    v = 17'd45042;
        4'd7:    v = 17'd42313;
        4'd8:    v = 17'd39750;
        4'd9:    v = 17'd37341;
        4'd10:   v = 17'd35079;
        4'd11:   v = 17'd32954;
        4'd12:   v = 17'd30957;
        4'd13:   v = 17'd29081;
        4'd14:   v = 17'd27319;
        default: v = 17'd25664;
      endcase
      return v;
    end
  endfunction

endpackage

[hdl/tnps_mul.sv]
// ----------------------------------------------------------------------------
// tnps_mul: bit-serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle,
// finishing as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module tnps_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tnps_pkg::mul_req_t   req,
  output tnps_pkg::unit_res_t  res
);

  logic                           busy_r;
  logic                           done_r;
  logic signed [tnps_pkg::DW-1:0] acc_r;
  logic signed [tnps_pkg::DW-1:0] mc_r;
  logic [tnps_pkg::MW-1:0]        mp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (mp_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      mc_r  <= req.mcand;
      mp_r  <= req.mplier;
    end else if (busy_r && (mp_r != '0)) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign res.done  = done_r;
  assign res.value = acc_r;

endmodule

[hdl/tnps_div.sv]
// ----------------------------------------------------------------------------
// tnps_div: bit-serial restoring divider
// Signed dividend over unsigned divisor, one quotient bit per cycle, with an
// optional round-half-away-from-zero bias added to the magnitude at load.
// ----------------------------------------------------------------------------
module tnps_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tnps_pkg::div_req_t   req,
  output tnps_pkg::unit_res_t  res
);

  localparam int CW = $clog2(tnps_pkg::DW);

  logic                           busy_r;
  logic                           done_r;
  logic [CW-1:0]                  cnt_r;
  logic                           neg_r;
  logic [tnps_pkg::DENW-1:0]      den_r;
  logic [tnps_pkg::DENW:0]        rem_r;
  logic [tnps_pkg::DW-1:0]        quo_r;
  logic signed [tnps_pkg::DW-1:0] res_r;

  logic [tnps_pkg::DENW:0]        rem_sh;
  logic                           fits;
  logic [tnps_pkg::DENW:0]        rem_nx;
  logic [tnps_pkg::DW-1:0]        quo_nx;
  logic [tnps_pkg::DW-1:0]        mag;
  logic [tnps_pkg::DW-1:0]        bias;

  assign rem_sh = {rem_r[tnps_pkg::DENW-1:0], quo_r[tnps_pkg::DW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign rem_nx = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
  assign quo_nx = {quo_r[tnps_pkg::DW-2:0], fits};
  assign bias   = req.rnd ? tnps_pkg::DW'(req.den >> 1) : '0;
  assign mag    = (req.num[tnps_pkg::DW-1] ? (-req.num) : req.num) + bias;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= CW'(tnps_pkg::DW - 1);
      neg_r <= req.num[tnps_pkg::DW-1];
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= mag;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= rem_nx;
      quo_r <= quo_nx;
      if (cnt_r == '0) begin
        res_r <= neg_r ? -$signed(quo_nx) : $signed(quo_nx);
      end
    end
  end

  assign res.done  = done_r;
  assign res.value = res_r;

endmodule

[hdl/three_node_thermal_plant_step_unit.sv]
// ----------------------------------------------------------------------------
// three_node_thermal_plant_step_unit: three-node heater plant, one Euler step
// A tick that does not complete a step is taken and gives nothing.
// A completing tick runs 22 operations on a bit-serial multiplier and a
// bit-serial divider.
// One tick at a time; the next is taken once the result is in the output register.
// Synchronous active-low reset restores state, config and start temperatures.
// ----------------------------------------------------------------------------
module three_node_thermal_plant_step_unit #(
  parameter int START_TEMP  = 5120,
  parameter int STEP_MIN_MS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // elapsed_ms, duty, flow_rate, inlet_temp
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // block_temp, heater_temp, sensor_temp
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  localparam int DW   = tnps_pkg::DW;
  localparam int MW   = tnps_pkg::MW;
  localparam int DENW = tnps_pkg::DENW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    ST_X, ST_E, ST_A0, ST_A1, ST_QF, ST_QL, ST_QE, ST_GHW, ST_GWS, ST_GHS,
    ST_QHW, ST_QWS, ST_QHS, ST_DH, ST_DW, ST_DS, ST_NH, ST_VH, ST_NW, ST_VW,
    ST_NS, ST_VS
  } step_t;

  state_t state_r;
  step_t  step_r;

  logic [11:0]        pwr_r;
  logic [13:0]        mass_r;
  logic [15:0]        loss_r;
  logic signed [14:0] amb_r;
  logic [15:0]        k_r;
  logic [9:0]         dwh_r;
  logic [9:0]         dws_r;
  logic [9:0]         dsh_r;

  logic signed [17:0] blk_r;
  logic signed [17:0] htr_r;
  logic signed [17:0] snr_r;
  logic [16:0]        pend_r;

  logic [16:0]        dt_r;
  logic [16:0]        duty_r;
  logic [11:0]        flow_r;
  logic signed [15:0] inlet_r;

  logic [7:0]           x_r;
  logic [16:0]          eff_r;
  logic signed [DW-1:0] t_r;
  logic signed [DW-1:0] sh_r;
  logic signed [DW-1:0] sw_r;
  logic signed [DW-1:0] ss_r;
  logic signed [DW-1:0] nh_r;
  logic signed [DW-1:0] nw_r;
  logic signed [DW-1:0] ns_r;
  logic [16:0]          ghw_r;
  logic [16:0]          gws_r;
  logic [16:0]          ghs_r;
  logic [DENW-1:0]      denh_r;
  logic [DENW-1:0]      denw_r;
  logic [DENW-1:0]      dens_r;

  logic        out_valid_r;
  logic [55:0] out_data_r;

  tnps_pkg::mul_req_t  mreq;
  tnps_pkg::div_req_t  dreq;
  tnps_pkg::unit_res_t mres;
  tnps_pkg::unit_res_t dres;

  logic [15:0]          in_elapsed;
  logic [16:0]          in_duty;
  logic [11:0]          in_flow;
  logic signed [15:0]   in_inlet;
  logic                 in_xfer;
  logic [17:0]          pend_sum;
  logic [16:0]          pend_sat;
  logic                 fire;
  logic                 heat_mode;
  logic                 sens_mode;
  logic [13:0]          mass_eff;
  logic signed [18:0]   d_wi;
  logic signed [18:0]   d_wa;
  logic signed [18:0]   d_hw;
  logic signed [18:0]   d_ws;
  logic signed [18:0]   d_hs;
  logic                 unit_done;
  logic signed [DW-1:0] rv;
  logic signed [DW-1:0] rq;
  logic signed [DW-1:0] e_sum;
  logic signed [DW-1:0] lo;
  logic signed [DW-1:0] fin_h;
  logic signed [DW-1:0] fin_s;

  function automatic logic signed [17:0] clamp_node(input logic signed [DW-1:0] t,
                                                    input logic signed [DW-1:0] l);
    logic signed [DW-1:0] v;
    begin
      v = t;
      if (v < l) v = l;
      if (v > DW'(tnps_pkg::TEMP_CEIL)) v = DW'(tnps_pkg::TEMP_CEIL);
      return v[17:0];
    end
  endfunction

  tnps_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .res(mres));
  tnps_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .res(dres));

  assign in_elapsed = in_tdata[15:0];
  assign in_duty    = in_tdata[32:16];
  assign in_flow    = in_tdata[44:33];
  assign in_inlet   = in_tdata[60:45];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign pend_sum = 18'(pend_r) + 18'(in_elapsed);
  assign pend_sat = (pend_sum > 18'(tnps_pkg::PENDING_MAX)) ? tnps_pkg::PENDING_MAX
                                                            : pend_sum[16:0];
  assign fire     = pend_sat >= 17'(STEP_MIN_MS);

  assign heat_mode = (dwh_r != '0) || (dsh_r != '0);
  assign sens_mode = (dws_r != '0) || (dsh_r != '0);
  assign mass_eff  = (mass_r == '0) ? 14'd1 : mass_r;

  assign d_wi = 19'(blk_r) - 19'(inlet_r);
  assign d_wa = 19'(blk_r) - 19'(amb_r);
  assign d_hw = 19'(htr_r) - 19'(blk_r);
  assign d_ws = 19'(blk_r) - 19'(snr_r);
  assign d_hs = 19'(htr_r) - 19'(snr_r);

  assign unit_done = mres.done || dres.done;
  assign rv        = dres.done ? dres.value : mres.value;
  // divide by 2^16, halves away from zero
  assign rq        = (rv + (rv[DW-1] ? DW'(32767) : DW'(32768))) >>> 16;
  assign e_sum     = rv + DW'(32768);

  assign lo    = DW'(amb_r) - DW'(tnps_pkg::FLOOR_OFFSET);
  assign fin_h = heat_mode ? nh_r : nw_r;
  assign fin_s = sens_mode ? ns_r : nw_r;

  // operand selection for the serial units
  always_comb begin
    mreq = '0;
    dreq = '0;
    if (state_r == S_ISSUE) begin
      unique case (step_r)
        ST_X: begin
          dreq.start = 1'b1;
          dreq.num   = DW'({k_r, 5'b0}) + DW'(flow_r);
          dreq.den   = DENW'({flow_r, 1'b0});
        end
        ST_E: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(tnps_pkg::exp_int(x_r[7:4]));
          mreq.mplier = MW'(tnps_pkg::exp_frac(x_r[3:0]));
        end
        ST_A0: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(d_wi);
          mreq.mplier = MW'(flow_r);
        end
        ST_A1: begin
          mreq.start  = 1'b1;
          mreq.mcand  = t_r;
          mreq.mplier = MW'(tnps_pkg::CP_Q16);
        end
        ST_QF: begin
          mreq.start  = 1'b1;
          mreq.mcand  = t_r;
          mreq.mplier = MW'(eff_r);
        end
        ST_QL: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(d_wa);
          mreq.mplier = MW'(loss_r);
        end
        ST_QE: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(duty_r);
          mreq.mplier = MW'(pwr_r);
        end
        ST_GHW: begin
          dreq.start = 1'b1;
          dreq.num   = DW'(tnps_pkg::COND_NUM);
          dreq.den   = DENW'(dwh_r);
          dreq.rnd   = 1'b1;
        end
        ST_GWS: begin
          dreq.start = 1'b1;
          dreq.num   = DW'(tnps_pkg::COND_NUM);
          dreq.den   = DENW'(dws_r);
          dreq.rnd   = 1'b1;
        end
        ST_GHS: begin
          dreq.start = 1'b1;
          dreq.num   = DW'(tnps_pkg::COND_NUM);
          dreq.den   = DENW'(dsh_r);
          dreq.rnd   = 1'b1;
        end
        ST_QHW: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(d_hw);
          mreq.mplier = MW'(ghw_r);
        end
        ST_QWS: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(d_ws);
          mreq.mplier = MW'(gws_r);
        end
        ST_QHS: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(d_hs);
          mreq.mplier = MW'(ghs_r);
        end
        ST_DH: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(tnps_pkg::D_HEATER);
          mreq.mplier = MW'(mass_eff);
        end
        ST_DW: begin
          mreq.start  = 1'b1;
          mreq.mcand  = heat_mode ? DW'(tnps_pkg::D_BLOCK3) : DW'(tnps_pkg::D_BLOCK1);
          mreq.mplier = MW'(mass_eff);
        end
        ST_DS: begin
          mreq.start  = 1'b1;
          mreq.mcand  = DW'(tnps_pkg::D_SENSOR);
          mreq.mplier = MW'(mass_eff);
        end
        ST_NH: begin
          mreq.start  = 1'b1;
          mreq.mcand  = sh_r;
          mreq.mplier = MW'(dt_r);
        end
        ST_NW: begin
          mreq.start  = 1'b1;
          mreq.mcand  = sw_r;
          mreq.mplier = MW'(dt_r);
        end
        ST_NS: begin
          mreq.start  = 1'b1;
          mreq.mcand  = ss_r;
          mreq.mplier = MW'(dt_r);
        end
        ST_VH: begin
          dreq.start = 1'b1;
          dreq.num   = t_r;
          dreq.den   = denh_r;
          dreq.rnd   = 1'b1;
        end
        ST_VW: begin
          dreq.start = 1'b1;
          dreq.num   = t_r;
          dreq.den   = denw_r;
          dreq.rnd   = 1'b1;
        end
        ST_VS: begin
          dreq.start = 1'b1;
          dreq.num   = t_r;
          dreq.den   = dens_r;
          dreq.rnd   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwr_r  <= 12'd1000;
      mass_r <= 14'd500;
      loss_r <= 16'd256;
      amb_r  <= 15'sd6400;
      k_r    <= 16'd256;
      dwh_r  <= '0;
      dws_r  <= '0;
      dsh_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tnps_pkg::REG_POWER: pwr_r  <= cfg_wdata[11:0];
        tnps_pkg::REG_MASS:  mass_r <= cfg_wdata[13:0];
        tnps_pkg::REG_LOSS:  loss_r <= cfg_wdata;
        tnps_pkg::REG_AMB:   amb_r  <= cfg_wdata[14:0];
        tnps_pkg::REG_FLOWK: k_r    <= cfg_wdata;
        tnps_pkg::REG_DWH:   dwh_r  <= cfg_wdata[9:0];
        tnps_pkg::REG_DWS:   dws_r  <= cfg_wdata[9:0];
        tnps_pkg::REG_DSH:   dsh_r  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // sequencer and plant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_X;
      pend_r      <= '0;
      blk_r       <= 18'(START_TEMP);
      htr_r       <= 18'(START_TEMP);
      snr_r       <= 18'(START_TEMP);
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (fire) begin
              pend_r  <= '0;
              step_r  <= ST_X;
              state_r <= S_ISSUE;
            end else begin
              pend_r <= pend_sat;
            end
          end
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (unit_done) begin
            if (step_r == ST_VS) begin
              state_r <= S_FIN;
            end else begin
              step_r  <= step_t'(step_r + 5'd1);
              state_r <= S_ISSUE;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            blk_r   <= clamp_node(nw_r, lo);
            htr_r   <= clamp_node(fin_h, lo);
            snr_r   <= clamp_node(fin_s, lo);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer && fire) begin
      dt_r    <= pend_sat;
      duty_r  <= (in_duty > tnps_pkg::ONE_Q16) ? tnps_pkg::ONE_Q16 : in_duty;
      flow_r  <= in_flow;
      inlet_r <= in_inlet;
      sh_r    <= '0;
      sw_r    <= '0;
      ss_r    <= '0;
    end
    if ((state_r == S_FIN) && (!out_valid_r || out_tready)) begin
      out_data_r <= {2'b00, clamp_node(fin_s, lo), clamp_node(fin_h, lo),
                     clamp_node(nw_r, lo)};
    end
    if ((state_r == S_WAIT) && unit_done) begin
      case (step_r)
        ST_X:   x_r <= (rv > DW'(191)) ? 8'd192 : rv[7:0];
        ST_E:   eff_r <= (flow_r <= tnps_pkg::FLOW_EPS_RAW) ? tnps_pkg::ONE_Q16
                         : (tnps_pkg::ONE_Q16 - e_sum[32:16]);
        ST_A0:  t_r <= rv;
        ST_A1:  t_r <= rq;
        ST_QF:  sw_r <= sw_r - rq;
        ST_QL:  sw_r <= sw_r - rv;
        ST_QE: begin
          if (heat_mode) sh_r <= sh_r + rv;
          else sw_r <= sw_r + rv;
        end
        ST_GHW: ghw_r <= (dwh_r == '0) ? '0 : rv[16:0];
        ST_GWS: gws_r <= (dws_r == '0) ? '0 : rv[16:0];
        ST_GHS: ghs_r <= (dsh_r == '0) ? '0 : rv[16:0];
        ST_QHW: begin
          sh_r <= sh_r - rv;
          sw_r <= sw_r + rv;
        end
        ST_QWS: begin
          sw_r <= sw_r - rv;
          ss_r <= ss_r + rv;
        end
        ST_QHS: begin
          sh_r <= sh_r - rv;
          ss_r <= ss_r + rv;
        end
        ST_DH:  denh_r <= rv[DENW-1:0];
        ST_DW:  denw_r <= rv[DENW-1:0];
        ST_DS:  dens_r <= rv[DENW-1:0];
        ST_NH:  t_r <= rv;
        ST_NW:  t_r <= rv;
        ST_NS:  t_r <= rv;
        ST_VH:  nh_r <= DW'(htr_r) + rv;
        ST_VW:  nw_r <= DW'(blk_r) + rv;
        ST_VS:  ns_r <= DW'(snr_r) + rv;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/tnps_chk.sv]
// ----------------------------------------------------------------------------
// tnps_chk: port checker for the thermal plant step unit
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module tnps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset leaves no result and an open input
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("state after reset wrong");

  // every node at or below the ceiling
  a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[17:0]) <= 18'sd76800)
                && ($signed(out_tdata[35:18]) <= 18'sd76800)
                && ($signed(out_tdata[53:36]) <= 18'sd76800))
    else $error("node above ceiling");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:54] == 2'b00)
    else $error("padding bits set");

endmodule

bind three_node_thermal_plant_step_unit tnps_chk u_tnps_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);
